[rtl/core/gfnc_pkg.sv]
// Shared types, constants and GF(256) arithmetic for the network code decoder.
package gfnc_pkg;

  localparam int GFNC_GEN_SIZE = 16;
  localparam logic [7:0] GF_REDUCE = 8'h1b;
  localparam logic [7:0] GF_TOPBIT = 8'h80;

  // input op codes
  localparam logic OP_ELEM  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // request to / response from the inverse unit
  typedef struct packed {
    logic       start;
    logic [7:0] a;
  } inv_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } inv_rsp_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = '0;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ x;
      if ((x & GF_TOPBIT) != 8'h00) x = {x[6:0], 1'b0} ^ GF_REDUCE;
      else x = {x[6:0], 1'b0};
    end
    return p;
  endfunction

endpackage

[rtl/core/gfnc_row_ram.sv]
// Row store: one pivot row per word, registered read, one write port.
module gfnc_row_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 128,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/gfnc_inv.sv]
// Iterative GF(256) inverse: a^-1 = a^2 * a^4 * ... * a^128, one product per cycle.
module gfnc_inv
  import gfnc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  inv_req_t req,
  output inv_rsp_t rsp
);

  logic [7:0] base_r, base_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;

  always_comb begin
    base_nxt = base_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      base_nxt = gf_mul(req.a, req.a);
      acc_nxt  = 8'h01;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt  = gf_mul(acc_r, base_r);
      base_nxt = gf_mul(base_r, base_r);
      cnt_nxt  = cnt_r + 3'd1;
      if (cnt_r == 3'd6) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    base_r <= base_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = acc_r;

endmodule

[rtl/core/gf256_network_code_decoder.sv]
// GF(256) online Gauss-Jordan network code decoder, top level and sequencer.
// Non-last elements and clears are taken in the idle state. A last element runs forward
// elimination and, for an innovative vector, the inverse and back-substitution, all
// through the single row memory.
// Reset (synchronous, rst_n low) empties row valid bits, counts and incoming buffer;
// row memory contents are not cleared and their data is used only for valid rows.
module gf256_network_code_decoder
  import gfnc_pkg::*;
#(
  parameter int GEN_SIZE = GFNC_GEN_SIZE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] offset, [11:4] coeff_value, [15:12] zero
  input  logic [0:0]  in_tuser,   // [0] op
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] innovative, [5:1] seen_rows, [10:6] decoded_rows,
                                  // [15:11] span
);

  localparam int IW = $clog2(GEN_SIZE);
  localparam int CW = $clog2(GEN_SIZE + 1);
  localparam int RW = GEN_SIZE * 8;
  localparam logic [IW-1:0] LAST_COL = IW'(GEN_SIZE - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_FE     = 4'd2;
  localparam logic [3:0] S_FE_ACC = 4'd3;
  localparam logic [3:0] S_INV    = 4'd4;
  localparam logic [3:0] S_NORM   = 4'd5;
  localparam logic [3:0] S_BS     = 4'd6;
  localparam logic [3:0] S_BS_UPD = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  function automatic logic [IW-1:0] row_top(input logic [RW-1:0] r);
    logic [IW-1:0] t;
    t = '0;
    for (int j = 0; j < GEN_SIZE; j++) begin
      if (|r[j*8 +: 8]) t = IW'(j);
    end
    return t;
  endfunction

  function automatic logic row_unit(input logic [RW-1:0] r, input logic [IW-1:0] pos);
    logic u;
    u = (r[int'(pos)*8 +: 8] == 8'h01);
    for (int j = 0; j < GEN_SIZE; j++) begin
      if (j != int'(pos) && (|r[j*8 +: 8])) u = 1'b0;
    end
    return u;
  endfunction

  function automatic logic [4:0] sat5(input logic [CW-1:0] x);
    if (int'(x) > 31) return 5'd31;
    else return 5'(x);
  endfunction

  logic [3:0]          state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [RW-1:0]       v_r, v_nxt;
  logic [GEN_SIZE-1:0] valid_r, valid_nxt;
  logic [GEN_SIZE-1:0] unit_r, unit_nxt;
  logic [CW-1:0]       seen_r, seen_nxt;
  logic [CW-1:0]       dec_r, dec_nxt;
  logic [CW-1:0]       span_r, span_nxt;
  logic                innov_r, innov_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         out_data_r, out_data_nxt;

  logic                in_fire;
  logic                in_op;
  logic [3:0]          in_offset;
  logic [7:0]          in_coeff;
  logic [IW-1:0]       off_idx;
  logic                off_ok;

  logic [GEN_SIZE-1:0] v_nz;
  logic [IW-1:0]       v_top;
  logic [CW-1:0]       v_top_p1;
  logic [7:0]          cur_c;

  logic [RW-1:0]       mul_src;
  logic [7:0]          mul_c;
  logic [RW-1:0]       prod;

  logic                ram_rd_en;
  logic [RW-1:0]       ram_rd_data;
  logic                ram_we;
  logic [RW-1:0]       ram_wdata;

  logic [IW-1:0]       rd_top;
  logic [GEN_SIZE-1:0] bs_clr;
  logic                bs_stop;
  logic [RW-1:0]       bs_row;
  logic [IW-1:0]       bs_top;
  logic                bs_unit;
  logic                norm_unit;

  inv_req_t            inv_req;
  inv_rsp_t            inv_rsp;

  assign in_op     = in_tuser[0];
  assign in_offset = in_tdata[3:0];
  assign in_coeff  = in_tdata[11:4];
  assign off_idx   = IW'(in_offset);
  assign off_ok    = int'(in_offset) < GEN_SIZE;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    for (int j = 0; j < GEN_SIZE; j++) v_nz[j] = |v_r[j*8 +: 8];
  end
  assign v_top    = row_top(v_r);
  assign v_top_p1 = CW'(v_top) + CW'(1);
  assign cur_c    = v_r[int'(idx_r)*8 +: 8];

  // one bank of column multipliers, shared by elimination and normalization
  assign mul_src = (state_r == S_NORM) ? v_r : ram_rd_data;
  assign mul_c   = (state_r == S_NORM) ? inv_rsp.value : cur_c;
  always_comb begin
    for (int j = 0; j < GEN_SIZE; j++) prod[j*8 +: 8] = gf_mul(mul_src[j*8 +: 8], mul_c);
  end
  assign norm_unit = row_unit(prod, idx_r);

  // back-substitution of one row: clear columns of higher unit rows,
  // walking down from the row's top until a non-unit pivot row is met
  assign rd_top = row_top(ram_rd_data);
  always_comb begin
    bs_stop = 1'b0;
    bs_clr  = '0;
    for (int i = GEN_SIZE - 1; i >= 0; i--) begin
      if (i > int'(idx_r) && i <= int'(rd_top) && valid_r[i]) begin
        if (!unit_r[i]) bs_stop = 1'b1;
        else if (!bs_stop) bs_clr[i] = 1'b1;
      end
    end
    for (int j = 0; j < GEN_SIZE; j++) begin
      bs_row[j*8 +: 8] = bs_clr[j] ? 8'h00 : ram_rd_data[j*8 +: 8];
    end
  end
  assign bs_top  = row_top(bs_row);
  assign bs_unit = row_unit(bs_row, idx_r);

  assign ram_rd_en = (state_r == S_FE) || (state_r == S_BS);
  assign ram_wdata = (state_r == S_NORM) ? prod : bs_row;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    v_nxt         = v_r;
    valid_nxt     = valid_r;
    unit_nxt      = unit_r;
    seen_nxt      = seen_r;
    dec_nxt       = dec_r;
    span_nxt      = span_r;
    innov_nxt     = innov_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    inv_req.start = 1'b0;
    inv_req.a     = cur_c;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_CLEAR) begin
            valid_nxt = '0;
            unit_nxt  = '0;
            seen_nxt  = '0;
            dec_nxt   = '0;
            span_nxt  = '0;
            v_nxt     = '0;
          end else begin
            if (off_ok) v_nxt[int'(off_idx)*8 +: 8] = v_r[int'(off_idx)*8 +: 8] ^ in_coeff;
            if (in_tlast) state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        innov_nxt = 1'b0;
        if (v_nz == '0) begin
          state_nxt = S_FIN;
        end else begin
          if (v_top_p1 > span_r) span_nxt = v_top_p1;
          idx_nxt   = '0;
          state_nxt = S_FE;
        end
      end
      S_FE: begin
        if (cur_c == 8'h00) begin
          // ran off the end: every column cancelled, vector is now zero
          if (idx_r == LAST_COL) state_nxt = S_FIN;
          else idx_nxt = idx_r + IW'(1);
        end else if (!valid_r[idx_r]) begin
          inv_req.start = 1'b1;
          state_nxt     = S_INV;
        end else begin
          state_nxt = S_FE_ACC;
        end
      end
      S_FE_ACC: begin
        v_nxt     = v_r ^ prod;
        state_nxt = S_FE;
      end
      S_INV: begin
        if (inv_rsp.done) state_nxt = S_NORM;
      end
      S_NORM: begin
        ram_we           = 1'b1;
        valid_nxt[idx_r] = 1'b1;
        unit_nxt[idx_r]  = norm_unit;
        seen_nxt         = seen_r + CW'(1);
        dec_nxt          = dec_r + CW'(norm_unit);
        innov_nxt        = 1'b1;
        idx_nxt          = LAST_COL;
        state_nxt        = S_BS;
      end
      S_BS: begin
        if (valid_r[idx_r]) state_nxt = S_BS_UPD;
        else if (idx_r == '0) state_nxt = S_FIN;
        else idx_nxt = idx_r - IW'(1);
      end
      S_BS_UPD: begin
        ram_we = 1'b1;
        if (bs_unit && !unit_r[idx_r]) begin
          unit_nxt[idx_r] = 1'b1;
          dec_nxt         = dec_r + CW'(1);
        end
        if (bs_top != idx_r || idx_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r - IW'(1);
          state_nxt = S_BS;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {sat5(span_r), sat5(dec_r), sat5(seen_r), innov_r};
          v_nxt         = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      v_r         <= '0;
      valid_r     <= '0;
      unit_r      <= '0;
      seen_r      <= '0;
      dec_r       <= '0;
      span_r      <= '0;
      innov_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      v_r         <= v_nxt;
      valid_r     <= valid_nxt;
      unit_r      <= unit_nxt;
      seen_r      <= seen_nxt;
      dec_r       <= dec_nxt;
      span_r      <= span_nxt;
      innov_r     <= innov_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  gfnc_row_ram #(
    .DEPTH(GEN_SIZE),
    .WIDTH(RW),
    .AW   (IW)
  ) u_row_ram (
    .clk    (clk),
    .rd_en  (ram_rd_en),
    .rd_addr(idx_r),
    .rd_data(ram_rd_data),
    .wr_en  (ram_we),
    .wr_addr(idx_r),
    .wr_data(ram_wdata)
  );

  gfnc_inv u_inv (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (inv_req),
    .rsp  (inv_rsp)
  );

`ifndef SYNTHESIS
  a_seen_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(seen_r))
    else $error("seen count differs from number of valid rows");

  a_decoded_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
    int'(dec_r) <= int'(seen_r))
    else $error("decoded count exceeds stored rows");

  a_norm_free_pivot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NORM) |-> !valid_r[idx_r])
    else $error("new row written over an existing pivot row");

  a_acc_valid_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FE_ACC || state_r == S_BS_UPD) |-> valid_r[idx_r])
    else $error("row memory data used from an invalid row");

  a_inv_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    inv_rsp.done |-> (state_r == S_INV))
    else $error("inverse finished outside its wait state");
`endif

endmodule
